FILE: hw/rtl/bcrf_pkg.sv
// ----------------------------------------------------------------------------
// bcrf_pkg
// Shared types and constants of the bisection cubic root finder: datapath
// command codes, status bundle and the sign encoding of f(x).
// ----------------------------------------------------------------------------
package bcrf_pkg;

  localparam int unsigned TOL_WIDTH = 31;
  localparam int unsigned CNT_WIDTH = 7;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,   // capture interval, width and first limit
    OP_COUNT,  // one step of the iteration count search
    OP_XA,     // load clamped a into the evaluator
    OP_XB,     // load clamped b into the evaluator
    OP_XC,     // load clamped midpoint into the evaluator
    OP_MUL,    // product of running term and x
    OP_SUB,    // rescale product and subtract ten
    OP_SGNA,   // store sign of f(a)
    OP_SGNB,   // store sign of f(b)
    OP_UPD,    // sign of f(c) and interval update
    OP_MID,    // register the midpoint
    OP_OUT     // write the result register
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic grow;  // count search must continue
    logic last;  // current bisection step is the final one
  } stat_t;

  typedef struct packed {
    logic neg;
    logic nz;
  } sign_t;

endpackage

FILE: hw/rtl/bcrf_in_if.sv
// ----------------------------------------------------------------------------
// bcrf_in_if
// Input channel: interval ends and permissible error, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bcrf_in_if
  import bcrf_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] left_end;
  logic signed [VALUE_WIDTH-1:0] right_end;
  logic        [TOL_WIDTH-1:0]   tolerance;

  modport source (output valid, output left_end, output right_end, output tolerance,
                  input ready);
  modport sink   (input valid, input left_end, input right_end, input tolerance,
                  output ready);
endinterface

FILE: hw/rtl/bcrf_out_if.sv
// ----------------------------------------------------------------------------
// bcrf_out_if
// Output channel: root estimate and iteration count, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bcrf_out_if
  import bcrf_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] root_estimate;
  logic        [CNT_WIDTH-1:0]   iteration_count;

  modport source (output valid, output root_estimate, output iteration_count,
                  input ready);
  modport sink   (input valid, input root_estimate, input iteration_count,
                  output ready);
endinterface

FILE: hw/rtl/bcrf_datapath.sv
// ----------------------------------------------------------------------------
// bcrf_datapath
// Interval registers, count search, shared-multiplier Horner evaluator of
// f(x) = x^3 - 1.8x^2 - 10x + 17 and the result register.
// ----------------------------------------------------------------------------
module bcrf_datapath
  import bcrf_pkg::*;
#(
  parameter int unsigned MAX_ITER    = 64,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cmd_t                          cmd_i,
  output stat_t                         stat_o,
  input  logic signed [VALUE_WIDTH-1:0] left_end_i,
  input  logic signed [VALUE_WIDTH-1:0] right_end_i,
  input  logic        [TOL_WIDTH-1:0]   tolerance_i,
  output logic signed [VALUE_WIDTH-1:0] root_estimate_o,
  output logic        [CNT_WIDTH-1:0]   iteration_count_o
);

  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned XW = FRAC_BITS + 6;   // clamped x
  localparam int unsigned TW = FRAC_BITS + 11;  // running Horner term
  localparam int unsigned PW = TW + XW;         // product
  localparam int unsigned SW = PW - FRAC_BITS + 1;
  localparam int unsigned CW = (VW > XW) ? VW : XW;
  localparam int unsigned LW = (VW + 2 > TOL_WIDTH + 1) ? VW + 2 : TOL_WIDTH + 1;

  localparam longint ONE = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [TW-1:0] C_ONE_EIGHT = TW'((18 * ONE + 5) / 10);
  localparam logic signed [TW-1:0] C_TEN       = TW'(10 * ONE);
  localparam logic signed [SW-1:0] C_SEVENTEEN = SW'(17 * ONE);
  localparam logic signed [CW-1:0] X_LIMIT     = CW'(16 * ONE);

  function automatic logic opposite(sign_t x, sign_t y);
    return x.nz && y.nz && (x.neg != y.neg);
  endfunction

  logic signed [VW-1:0]    a_q, b_q, c_q;
  logic        [VW:0]      width_q;
  logic        [LW-1:0]    lim_q;
  logic        [CNT_WIDTH-1:0] n_q, done_q;
  logic signed [XW-1:0]    xc_q;
  logic signed [TW-1:0]    t_q;
  logic signed [PW-1:0]    p_q;
  sign_t                   sa_q, sb_q;
  logic signed [VW-1:0]    root_q;
  logic        [CNT_WIDTH-1:0] cnt_q;

  logic signed [VW-1:0]    x_sel;
  logic signed [CW-1:0]    x_ext, x_clamp;
  logic signed [XW-1:0]    xc_d;
  logic signed [VW:0]      diff, sum;
  logic        [VW:0]      width_d;
  logic signed [VW-1:0]    mid;
  logic signed [SW-1:0]    f_val;
  sign_t                   sc;
  logic                    flip_a, flip_b;

  always_comb begin
    unique case (cmd_i.op)
      OP_XB:   x_sel = b_q;
      OP_XC:   x_sel = c_q;
      default: x_sel = a_q;
    endcase
  end

  // the clamp keeps every intermediate of the Horner chain bounded
  assign x_ext   = CW'(x_sel);
  assign x_clamp = (x_ext > X_LIMIT) ? X_LIMIT : ((x_ext < -X_LIMIT) ? -X_LIMIT : x_ext);
  assign xc_d    = XW'(x_clamp);

  assign diff    = (VW+1)'(right_end_i) - (VW+1)'(left_end_i);
  assign width_d = diff[VW] ? $unsigned(-diff) : $unsigned(diff);

  assign sum = (VW+1)'(a_q) + (VW+1)'(b_q);
  assign mid = VW'(sum >>> 1);

  assign f_val  = SW'(p_q >>> FRAC_BITS) + C_SEVENTEEN;
  assign sc.neg = f_val[SW-1];
  assign sc.nz  = |f_val;
  assign flip_b = opposite(sc, sa_q);
  assign flip_a = opposite(sc, sb_q);

  assign stat_o.grow = (LW'(width_q) >= lim_q) && (n_q < CNT_WIDTH'(MAX_ITER));
  assign stat_o.last = (done_q == n_q - CNT_WIDTH'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      done_q <= '0;
    end else begin
      unique case (cmd_i.op)
        OP_LOAD: begin
          n_q    <= CNT_WIDTH'(1);
          done_q <= '0;
        end
        OP_COUNT: begin
          if (stat_o.grow) begin
            n_q <= n_q + CNT_WIDTH'(1);
          end
        end
        OP_UPD:  done_q <= done_q + CNT_WIDTH'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        a_q     <= left_end_i;
        b_q     <= right_end_i;
        width_q <= width_d;
        lim_q   <= LW'({tolerance_i, 1'b0});
      end
      OP_COUNT: begin
        if (stat_o.grow) begin
          lim_q <= lim_q << 1;
        end
      end
      OP_XA, OP_XB, OP_XC: begin
        xc_q <= xc_d;
        t_q  <= TW'(xc_d) - C_ONE_EIGHT;
      end
      OP_MUL:  p_q  <= PW'(t_q) * PW'(xc_q);
      OP_SUB:  t_q  <= TW'(p_q >>> FRAC_BITS) - C_TEN;
      OP_SGNA: sa_q <= sc;
      OP_SGNB: sb_q <= sc;
      OP_MID:  c_q  <= mid;
      OP_UPD: begin
        // both tests use the signs from the start of the step
        if (flip_b) begin
          b_q  <= c_q;
          sb_q <= sc;
        end
        if (flip_a) begin
          a_q  <= c_q;
          sa_q <= sc;
        end
      end
      OP_OUT: begin
        root_q <= mid;
        cnt_q  <= n_q;
      end
      default: ;
    endcase
  end

  assign root_estimate_o   = root_q;
  assign iteration_count_o = cnt_q;

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_COUNT && stat_o.grow) |=> (n_q <= CNT_WIDTH'(MAX_ITER)))
    else $error("iteration count exceeds limit");

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_UPD) |-> (done_q < n_q))
    else $error("bisection step beyond iteration count");

  a_out_count_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_OUT) |-> (n_q >= CNT_WIDTH'(1) && n_q <= CNT_WIDTH'(MAX_ITER)))
    else $error("result written with an iteration count out of range");

endmodule

FILE: hw/rtl/bcrf_ctrl.sv
// ----------------------------------------------------------------------------
// bcrf_ctrl
// Sequencer: count search, evaluation of f(a) and f(b), then one midpoint
// evaluation and interval update per bisection step, then the result.
// ----------------------------------------------------------------------------
module bcrf_ctrl
  import bcrf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_COUNT, S_LOAD, S_MUL1, S_SUB, S_MUL2, S_SIGN, S_MID, S_OUT
  } state_e;

  typedef enum logic [1:0] {T_A, T_B, T_C} tgt_e;

  state_e state_q;
  tgt_e   tgt_q;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.op = OP_NOP;
    unique case (state_q)
      S_IDLE:  cmd_o.op = in_valid_i ? OP_LOAD : OP_NOP;
      S_COUNT: cmd_o.op = OP_COUNT;
      S_LOAD: begin
        unique case (tgt_q)
          T_A:     cmd_o.op = OP_XA;
          T_B:     cmd_o.op = OP_XB;
          default: cmd_o.op = OP_XC;
        endcase
      end
      S_MUL1, S_MUL2: cmd_o.op = OP_MUL;
      S_SUB:   cmd_o.op = OP_SUB;
      S_SIGN: begin
        unique case (tgt_q)
          T_A:     cmd_o.op = OP_SGNA;
          T_B:     cmd_o.op = OP_SGNB;
          default: cmd_o.op = OP_UPD;
        endcase
      end
      S_MID:   cmd_o.op = OP_MID;
      S_OUT:   cmd_o.op = slot_free ? OP_OUT : OP_NOP;
      default: cmd_o.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tgt_q       <= T_A;
      out_valid_q <= 1'b0;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if (state_q == S_OUT && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_COUNT;
          end
        end
        S_COUNT: begin
          if (!stat_i.grow) begin
            tgt_q   <= T_A;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: state_q <= S_MUL1;
        S_MUL1: state_q <= S_SUB;
        S_SUB:  state_q <= S_MUL2;
        S_MUL2: state_q <= S_SIGN;
        S_SIGN: begin
          unique case (tgt_q)
            T_A: begin
              tgt_q   <= T_B;
              state_q <= S_LOAD;
            end
            T_B:     state_q <= S_MID;
            default: state_q <= stat_i.last ? S_OUT : S_MID;
          endcase
        end
        S_MID: begin
          tgt_q   <= T_C;
          state_q <= S_LOAD;
        end
        S_OUT: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_OUT) |-> (!out_valid_q || out_ready_i))
    else $error("result register written while a transaction is pending");

  a_valid_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.op == OP_OUT))
    else $error("output valid raised without a result write");

  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_LOAD) |=> (state_q == S_COUNT))
    else $error("load did not start the count search");

endmodule

FILE: hw/rtl/bisection_cubic_root_finder.sv
// ----------------------------------------------------------------------------
// bisection_cubic_root_finder
// Bisection root finder for f(x) = x^3 - 1.8x^2 - 10x + 17 in signed fixed
// point.
// ----------------------------------------------------------------------------
// usage:
//   in_i carries an interval (left_end, right_end) and a tolerance; out_o
//   returns the root estimate and the number of bisection steps n, one
//   transaction out for each transaction in.
//   n is the smallest count >= 1 with |b - a| / 2^n below the tolerance,
//   saturated at MAX_ITER.
//   from an input transaction to output valid the sequencer runs the count
//   search, evaluates f(a) and f(b), then evaluates the midpoint and updates
//   the interval in each step, and finally writes the result. Each step is
//   bound by the one shared multiplier that each evaluation uses twice.
//   one item is in flight at a time; in_i.ready is high when the sequencer
//   is idle. The result sits in an output register, so a new item can be
//   taken while the receiver stalls; the next result waits until the
//   register is free.
//   reset clears the sequencer and output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bisection_cubic_root_finder
  import bcrf_pkg::*;
#(
  parameter int unsigned MAX_ITER    = 64,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bcrf_in_if.sink     in_i,
  bcrf_out_if.source  out_o
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;
  logic  out_valid;

  bcrf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bcrf_datapath #(
    .MAX_ITER    (MAX_ITER),
    .FRAC_BITS   (FRAC_BITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .left_end_i        (in_i.left_end),
    .right_end_i       (in_i.right_end),
    .tolerance_i       (in_i.tolerance),
    .root_estimate_o   (out_o.root_estimate),
    .iteration_count_o (out_o.iteration_count)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule
